@@ design/sssp_pkg.sv @@
// shared constants for the single-source shortest path block
`timescale 1ns / 1ps

package sssp_pkg;

  // node ids and node counts
  localparam int NODE_W  = 6;
  localparam int NODES   = 64;
  localparam int COUNT_W = 7;

  // edge weight as it arrives on the input word
  localparam int WEIGHT_IN_W = 16;

  // tentative distance width and the largest reportable distance
  localparam int DIST_W     = 23;
  localparam int OUT_DIST_W = 22;
  localparam logic [OUT_DIST_W-1:0] DIST_MAX = {OUT_DIST_W{1'b1}};

  // parameter defaults
  localparam int EDGES_DEFAULT       = 1024;
  localparam int WEIGHT_BITS_DEFAULT = 16;

  // configuration port: register index taken from the top address bit
  localparam int ADDR_W  = 3;
  localparam int CFG_W   = 32;
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(NODES);

endpackage

@@ design/sssp_ram.sv @@
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/single_source_shortest_path_top.sv @@
// top level: edge loading, dijkstra sequencer and per-node result output
//
//  channel   direction  handshake                 payload
//  ------    ---------  ---------                 -------
//  edge      in         start & !busy             from_node, to_node, weight, last_edge
//  result    out        result_valid (1 cycle)    node_index, distance, reachable,
//                                                 edges_dropped, last_result
//  config    in         psel&penable&pwrite       paddr, pwdata (prdata on reads)
//
// an edge word without last_edge leaves busy low
// a word with last_edge starts the search: an init step, then per settled node one
//   scan over the distance ram, then a pass over the stored edges with an extra update
//   step when the edge leaves the settled node toward an open node in range, then a
//   final scan and the output, one result word per cycle in node order
// the registered read ports of the shared distance ram and the edge ram shape these steps
// rst is synchronous; it clears the sequencer, fill count and drop flag and resets the registers
// results cannot be stalled; busy holds off new edge words during the search
`timescale 1ns / 1ps

module single_source_shortest_path_top #(
  parameter int EDGES       = sssp_pkg::EDGES_DEFAULT,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // edge words
  input  logic                              start,
  output logic                              busy,
  input  logic [sssp_pkg::NODE_W-1:0]       from_node,
  input  logic [sssp_pkg::NODE_W-1:0]       to_node,
  input  logic [sssp_pkg::WEIGHT_IN_W-1:0]  weight,
  input  logic                              last_edge,
  // result words
  output logic                              result_valid,
  output logic [sssp_pkg::NODE_W-1:0]       node_index,
  output logic [sssp_pkg::OUT_DIST_W-1:0]   distance,
  output logic                              reachable,
  output logic                              edges_dropped,
  output logic                              last_result,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sssp_pkg::ADDR_W-1:0]       paddr,
  input  logic [sssp_pkg::CFG_W-1:0]        pwdata,
  output logic [sssp_pkg::CFG_W-1:0]        prdata,
  output logic                              pready
);

  import sssp_pkg::*;

  localparam int WSTORE = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
  localparam int EDGE_W = 2 * NODE_W + WSTORE;
  localparam int EA     = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int FW     = $clog2(EDGES + 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INIT      = 9'b000000010,
    S_FIND_RD   = 9'b000000100,
    S_FIND_CMP  = 9'b000001000,
    S_RELAX_RD  = 9'b000010000,
    S_RELAX_CHK = 9'b000100000,
    S_RELAX_UPD = 9'b001000000,
    S_OUT_RD    = 9'b010000000,
    S_OUT_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [COUNT_W-1:0] node_count;
  logic [NODE_W-1:0]  source_node;

  // edge store bookkeeping
  logic [FW-1:0] fill;
  logic          overflow;
  logic [FW-1:0] k;
  logic [FW-1:0] k_inc;

  // search state
  logic [NODE_W-1:0] scan;
  logic              found;
  logic [NODE_W-1:0] best_node;
  logic [DIST_W-1:0] best_dist;
  logic [NODE_W-1:0] u_node;
  logic [DIST_W-1:0] u_dist;
  logic [NODES-1:0]  settled;
  logic [NODES-1:0]  valid;

  // ram ports
  logic              edge_we;
  logic [EA-1:0]     edge_ra;
  logic [EDGE_W-1:0] edge_wd;
  logic [EDGE_W-1:0] edge_rd;
  logic              dist_we;
  logic [NODE_W-1:0] dist_wa;
  logic [DIST_W-1:0] dist_wd;
  logic [NODE_W-1:0] dist_ra;
  logic [DIST_W-1:0] dist_rd;

  // derived values
  logic [COUNT_W-1:0] n_act;
  logic [NODE_W-1:0]  n_last;
  logic               edges_full;
  logic               cfg_wr;
  logic               src_ok;
  logic [NODE_W-1:0]  e_src;
  logic [NODE_W-1:0]  e_dst;
  logic [WSTORE-1:0]  e_w;
  logic               relevant;
  logic [DIST_W:0]    cand_wide;
  logic [DIST_W-1:0]  cand;
  logic               upd_take;
  logic               sel;
  logic               found_n;
  logic [NODE_W-1:0]  bn;
  logic [DIST_W-1:0]  bd;
  logic [DIST_W-1:0]  d_out;
  logic               relax_done;

  // active node count, clamped to 1..NODES
  always_comb begin
    if (node_count == '0) begin
      n_act = COUNT_W'(1);
    end else if (node_count > COUNT_W'(NODES)) begin
      n_act = COUNT_W'(NODES);
    end else begin
      n_act = node_count;
    end
  end
  assign n_last     = NODE_W'(n_act - COUNT_W'(1));
  assign edges_full = (fill == FW'(EDGES));
  assign src_ok     = ({1'b0, source_node} < n_act);
  assign k_inc      = k + FW'(1);
  assign relax_done = (k_inc == fill);

  // stored edge fields
  assign e_src = edge_rd[EDGE_W-1 -: NODE_W];
  assign e_dst = edge_rd[EDGE_W-NODE_W-1 -: NODE_W];
  assign e_w   = edge_rd[WSTORE-1:0];

  // edge leaves the settled node toward an open in-range node
  assign relevant = (e_src == u_node) && ({1'b0, e_dst} < n_act) && !settled[e_dst];

  // candidate distance, saturated
  assign cand_wide = {1'b0, u_dist} + (DIST_W + 1)'(e_w);
  assign cand      = cand_wide[DIST_W] ? {DIST_W{1'b1}} : cand_wide[DIST_W-1:0];
  assign upd_take  = !valid[e_dst] || (cand < dist_rd);

  // minimum search over unsettled nodes, one node per cycle
  assign sel     = valid[scan] && !settled[scan] && (!found || dist_rd < best_dist);
  assign found_n = found || sel;
  assign bn      = sel ? scan : best_node;
  assign bd      = sel ? dist_rd : best_dist;

  // reported distance
  always_comb begin
    d_out = valid[scan] ? dist_rd : '0;
    if (d_out > DIST_W'(DIST_MAX)) begin
      d_out = DIST_W'(DIST_MAX);
    end
  end

  // edge store ports
  assign edge_we = (state == S_IDLE) && start && !edges_full;
  assign edge_wd = {from_node, to_node, weight[WSTORE-1:0]};
  always_comb begin
    if (state == S_RELAX_UPD || (state == S_RELAX_CHK && !relevant)) begin
      edge_ra = k_inc[EA-1:0];
    end else begin
      edge_ra = k[EA-1:0];
    end
  end

  // distance store ports
  always_comb begin
    dist_we = 1'b0;
    dist_wa = e_dst;
    dist_wd = cand;
    dist_ra = scan;
    case (state)
      S_INIT: begin
        dist_we = src_ok;
        dist_wa = source_node;
        dist_wd = '0;
      end
      S_RELAX_UPD: begin
        dist_we = upd_take;
      end
      S_RELAX_CHK: begin
        dist_ra = e_dst;
      end
      S_FIND_CMP, S_OUT_EMIT: begin
        dist_ra = scan + NODE_W'(1);
      end
      default: begin
        dist_ra = scan;
      end
    endcase
  end

  sssp_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (EDGES),
    .AW    (EA)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (edge_we),
    .wr_addr (fill[EA-1:0]),
    .wr_data (edge_wd),
    .rd_addr (edge_ra),
    .rd_data (edge_rd)
  );

  sssp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (NODES),
    .AW    (NODE_W)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_wa),
    .wr_data (dist_wd),
    .rd_addr (dist_ra),
    .rd_data (dist_rd)
  );

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[ADDR_W-1])
      REG_NODE_COUNT:  prdata = CFG_W'(node_count);
      REG_SOURCE_NODE: prdata = CFG_W'(source_node);
      default:         prdata = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      overflow     <= 1'b0;
      node_count   <= NODE_COUNT_RESET;
      source_node  <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      // register writes
      if (cfg_wr) begin
        case (paddr[ADDR_W-1])
          REG_NODE_COUNT:  node_count  <= pwdata[COUNT_W-1:0];
          REG_SOURCE_NODE: source_node <= pwdata[NODE_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            if (edges_full) begin
              overflow <= 1'b1;
            end else begin
              fill <= fill + FW'(1);
            end
            if (last_edge) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          settled <= '0;
          valid   <= '0;
          if (src_ok) begin
            valid[source_node] <= 1'b1;
          end
          scan  <= '0;
          found <= 1'b0;
          state <= S_FIND_RD;
        end
        S_FIND_RD: begin
          state <= S_FIND_CMP;
        end
        S_FIND_CMP: begin
          if (scan == n_last) begin
            scan  <= '0;
            found <= 1'b0;
            if (found_n) begin
              settled[bn] <= 1'b1;
              u_node      <= bn;
              u_dist      <= bd;
              k           <= '0;
              state       <= (fill == '0) ? S_FIND_RD : S_RELAX_RD;
            end else begin
              state <= S_OUT_RD;
            end
          end else begin
            scan      <= scan + NODE_W'(1);
            found     <= found_n;
            best_node <= bn;
            best_dist <= bd;
          end
        end
        S_RELAX_RD: begin
          state <= S_RELAX_CHK;
        end
        S_RELAX_CHK, S_RELAX_UPD: begin
          if (state == S_RELAX_UPD && upd_take) begin
            valid[e_dst] <= 1'b1;
          end
          if (state == S_RELAX_CHK && relevant) begin
            state <= S_RELAX_UPD;
          end else if (relax_done) begin
            scan  <= '0;
            found <= 1'b0;
            state <= S_FIND_RD;
          end else begin
            k     <= k_inc;
            state <= S_RELAX_CHK;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          result_valid  <= 1'b1;
          node_index    <= scan;
          distance      <= d_out[OUT_DIST_W-1:0];
          reachable     <= valid[scan];
          edges_dropped <= overflow;
          last_result   <= (scan == n_last);
          if (scan == n_last) begin
            fill     <= '0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end else begin
            scan <= scan + NODE_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result word only follows an output cycle of the sequencer
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_OUT_EMIT))
    else $error("result word without output cycle");

  // an edge word without the last mark leaves the block ready
  a_plain_edge_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_edge) |=> !busy)
    else $error("plain edge word made the block busy");

  // the fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(EDGES))
    else $error("edge fill beyond store depth");

  // the closing result word empties the edge store for the next graph
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> (fill == '0 && !overflow && !busy))
    else $error("edge store not emptied after last result");

  // no edge is relaxed from an unsettled node
  a_relax_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX_UPD) |-> settled[u_node])
    else $error("relaxing from an unsettled node");

endmodule
